/* rtl/core/ghs_pkg.sv */
// Package for the gyro heading-hold steering unit.
// Holds the fixed-point constants, register indexes and the slew delay map.
// No dependencies.
`default_nettype none

package ghs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegGyroBias    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSteeringGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegServoMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegServoMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegServoSpeed  = 3'd4;

  // Q9.16 degrees
  localparam logic [25:0] YawFull  = 26'd23592960;
  localparam logic [25:0] YawHalf  = 26'd11796480;
  // round(2^32 * 16 * 180 / (pi * 1e6))
  localparam logic [21:0] Rad2DegK = 22'd3937336;

  localparam logic [7:0] AngLow  = 8'd45;
  localparam logic [7:0] AngHigh = 8'd135;
  localparam logic [7:0] AngMid  = 8'd90;
  localparam logic [8:0] AngSpan = 9'd45;

  localparam logic [5:0]  DelaySlow = 6'd50;
  localparam logic [15:0] GainReset = 16'd655;

  // 50 - speed*45/255, divide by 255 through reciprocal (exact below 65535)
  function automatic logic [5:0] slew_delay(input logic [7:0] speed);
    logic [13:0] prod;
    logic [13:0] quo;
    prod = 14'({6'd0, speed} * 14'd45);
    quo  = (prod + 14'd1 + (prod >> 8)) >> 8;
    return DelaySlow - quo[5:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gyro_heading_hold_steering_unit.sv */
// Top level of the gyro heading-hold steering unit: yaw integration, heading
// error steering and servo slew, built around one bit-serial shift-add multiplier.
// Depends on ghs_pkg.
//
//  channel   | direction | handshake                    | word
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser: cmd; tdata: rate_z,
//            |           |                              |   elapsed_us, direction
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: yaw_deg, servo_target,
//            |           |                              |   servo_angle
//  cfg       | in        | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// A sample word runs from acceptance to the next acceptance through three
// serial multiplies (16, 22 and 16 multiplier bits, one multiplier bit per cycle)
// plus eleven further steps; a tick word skips the multiplies and goes through the tick step. Input is taken only
// in idle; a result waiting on m_axis does not block the next word, but a
// finished word holds until the output register is free. Reset is
// asynchronous, active low, and needs no clearing pass.
`default_nettype none

module gyro_heading_hold_steering_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [39:0]                   s_axis_tdata,  // rate_z, elapsed_us, direction
  input  wire logic                          s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [47:0]                        m_axis_tdata,  // yaw_deg, servo_target, servo_angle
  input  wire logic                          cfg_we_i,
  input  wire logic [ghs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ghs_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABS   = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_M2SET = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_YAW   = 4'd5;
  localparam logic [3:0] S_WRAP  = 4'd6;
  localparam logic [3:0] S_ERR   = 4'd7;
  localparam logic [3:0] S_EWRAP = 4'd8;
  localparam logic [3:0] S_M3SET = 4'd9;
  localparam logic [3:0] S_MUL3  = 4'd10;
  localparam logic [3:0] S_STEER = 4'd11;
  localparam logic [3:0] S_CLAMP = 4'd12;
  localparam logic [3:0] S_TICK  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // configuration
  logic [15:0] bias_q;
  logic [15:0] gain_q;
  logic [7:0]  smin_q;
  logic [7:0]  smax_q;
  logic [7:0]  speed_q;

  // control and state
  logic [3:0]  state_q, state_d;
  logic [24:0] yaw_q, yaw_d;
  logic [24:0] tyaw_q, tyaw_d;
  logic        ldv_q, ldv_d;
  logic        ld_q, ld_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  angle_q, angle_d;
  logic [5:0]  wait_q, wait_d;
  logic        mvalid_q, mvalid_d;
  logic [4:0]  cnt_q, cnt_d;

  // datapath
  logic signed [16:0] diff_q, diff_d;
  logic [15:0]        us_q, us_d;
  logic               dir_q, dir_d;
  logic               neg_q, neg_d;
  logic [33:0]        mcand_q, mcand_d;
  logic [21:0]        mul_q, mul_d;
  logic [55:0]        acc_q, acc_d;
  logic signed [25:0] wide_q, wide_d;
  logic [7:0]         ang_q, ang_d;
  logic [47:0]        mdata_q, mdata_d;

  logic [34:0] psum;
  logic [16:0] rate_mag;
  logic [22:0] qinc;
  logic [25:0] err_mag;
  logic [8:0]  hi;
  logic        capture;
  logic [7:0]  step_ang;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  always_comb begin
    psum     = {1'b0, acc_q[55:22]} + (mul_q[0] ? {1'b0, mcand_q} : 35'd0);
    rate_mag = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
    qinc     = acc_q[54:32] + {22'd0, acc_q[31]};
    err_mag  = wide_q[25] ? 26'(-wide_q) : 26'(wide_q);
    hi       = {1'b0, acc_q[45:38]} + {8'd0, neg_q & (|acc_q[37:6])};
    capture  = !ldv_q || (dir_q != ld_q);
    step_ang = (angle_q < target_q) ? angle_q + 8'd1 : angle_q - 8'd1;
  end

  always_comb begin
    state_d  = state_q;
    yaw_d    = yaw_q;
    tyaw_d   = tyaw_q;
    ldv_d    = ldv_q;
    ld_d     = ld_q;
    target_d = target_q;
    angle_d  = angle_q;
    wait_d   = wait_q;
    mvalid_d = mvalid_q;
    cnt_d    = cnt_q;
    diff_d   = diff_q;
    us_d     = us_q;
    dir_d    = dir_q;
    neg_d    = neg_q;
    mcand_d  = mcand_q;
    mul_d    = mul_q;
    acc_d    = acc_q;
    wide_d   = wide_q;
    ang_d    = ang_q;
    mdata_d  = mdata_q;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          diff_d  = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                    - $signed({bias_q[15], bias_q});
          us_d    = s_axis_tdata[31:16];
          dir_d   = s_axis_tdata[32];
          state_d = s_axis_tuser ? S_TICK : S_ABS;
        end
      end
      S_ABS: begin
        neg_d   = diff_q[16];
        mcand_d = {17'd0, rate_mag};
        mul_d   = {6'd0, us_q};
        acc_d   = '0;
        cnt_d   = 5'd15;
        state_d = S_MUL1;
      end
      S_MUL1, S_MUL2, S_MUL3: begin
        acc_d = {psum, acc_q[21:1]};
        mul_d = mul_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          case (state_q)
            S_MUL1:  state_d = S_M2SET;
            S_MUL2:  state_d = S_YAW;
            default: state_d = S_STEER;
          endcase
        end
      end
      S_M2SET: begin
        mcand_d = {1'b0, acc_q[38:6]};
        mul_d   = ghs_pkg::Rad2DegK;
        acc_d   = '0;
        cnt_d   = 5'd21;
        state_d = S_MUL2;
      end
      S_YAW: begin
        wide_d  = neg_q ? $signed({1'b0, yaw_q}) - $signed({3'd0, qinc})
                        : $signed({1'b0, yaw_q}) + $signed({3'd0, qinc});
        state_d = S_WRAP;
      end
      S_WRAP: begin
        if (wide_q[25]) begin
          yaw_d = 25'(wide_q + $signed(ghs_pkg::YawFull));
        end else if (wide_q >= $signed(ghs_pkg::YawFull)) begin
          yaw_d = 25'(wide_q - $signed(ghs_pkg::YawFull));
        end else begin
          yaw_d = wide_q[24:0];
        end
        state_d = S_ERR;
      end
      S_ERR: begin
        if (capture) begin
          tyaw_d = yaw_q;
          ldv_d  = 1'b1;
          ld_d   = dir_q;
          wide_d = '0;
        end else begin
          wide_d = $signed({1'b0, tyaw_q}) - $signed({1'b0, yaw_q});
        end
        state_d = S_EWRAP;
      end
      S_EWRAP: begin
        if (wide_q > $signed(ghs_pkg::YawHalf)) begin
          wide_d = wide_q - $signed(ghs_pkg::YawFull);
        end else if (wide_q < -$signed(ghs_pkg::YawHalf)) begin
          wide_d = wide_q + $signed(ghs_pkg::YawFull);
        end
        state_d = S_M3SET;
      end
      S_M3SET: begin
        neg_d   = wide_q[25] ^ dir_q;
        mcand_d = {10'd0, err_mag[23:0]};
        mul_d   = {6'd0, gain_q};
        acc_d   = '0;
        cnt_d   = 5'd15;
        state_d = S_MUL3;
      end
      S_STEER: begin
        if (hi > ghs_pkg::AngSpan) begin
          ang_d = neg_q ? ghs_pkg::AngLow : ghs_pkg::AngHigh;
        end else begin
          ang_d = neg_q ? ghs_pkg::AngMid - hi[7:0] : ghs_pkg::AngMid + hi[7:0];
        end
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        if (ang_q < smin_q) begin
          target_d = smin_q;
        end else if (ang_q > smax_q) begin
          target_d = smax_q;
        end else begin
          target_d = ang_q;
        end
        state_d = S_DONE;
      end
      S_TICK: begin
        if (wait_q != 6'd0) begin
          wait_d = wait_q - 6'd1;
        end else if (angle_q != target_q) begin
          angle_d = step_ang;
          wait_d  = ghs_pkg::slew_delay(speed_q) - 6'd1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {7'd0, angle_q, target_q, yaw_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= '0;
      gain_q  <= ghs_pkg::GainReset;
      smin_q  <= 8'd0;
      smax_q  <= 8'd180;
      speed_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ghs_pkg::RegGyroBias:     bias_q  <= cfg_data_i;
        ghs_pkg::RegSteeringGain: gain_q  <= cfg_data_i;
        ghs_pkg::RegServoMin:     smin_q  <= cfg_data_i[7:0];
        ghs_pkg::RegServoMax:     smax_q  <= cfg_data_i[7:0];
        ghs_pkg::RegServoSpeed:   speed_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      yaw_q    <= '0;
      tyaw_q   <= '0;
      ldv_q    <= 1'b0;
      ld_q     <= 1'b0;
      target_q <= ghs_pkg::AngMid;
      angle_q  <= ghs_pkg::AngMid;
      wait_q   <= '0;
      mvalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      yaw_q    <= yaw_d;
      tyaw_q   <= tyaw_d;
      ldv_q    <= ldv_d;
      ld_q     <= ld_d;
      target_q <= target_d;
      angle_q  <= angle_d;
      wait_q   <= wait_d;
      mvalid_q <= mvalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    us_q    <= us_d;
    dir_q   <= dir_d;
    neg_q   <= neg_d;
    mcand_q <= mcand_d;
    mul_q   <= mul_d;
    acc_q   <= acc_d;
    wide_q  <= wide_d;
    ang_q   <= ang_d;
    mdata_q <= mdata_d;
  end

  // hold the heading inside one turn
  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, yaw_q} < ghs_pkg::YawFull)
    else $error("heading left [0,360)");

  a_wait_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q < ghs_pkg::DelaySlow)
    else $error("slew wait above the slowest delay");

  a_angle_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_TICK) |=> $stable(angle_q))
    else $error("servo angle moved outside a tick");

  a_angle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK) |=> (angle_q == $past(angle_q)
                             || angle_q == $past(angle_q) + 8'd1
                             || angle_q == $past(angle_q) - 8'd1))
    else $error("servo angle stepped more than one degree");

endmodule

`default_nettype wire
